>>> hdl/binary32_float_adder_unit_macros.svh
// Assertion helpers for the float adder
`ifndef BINARY32_FLOAT_ADDER_UNIT_MACROS_SVH
`define BINARY32_FLOAT_ADDER_UNIT_MACROS_SVH

// implication checked every cycle outside reset
`define FA_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// implication checked in the cycle after the condition
`define FA_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> hdl/fadd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fadd_pkg
// Format constants and stage payload types of the binary32 adder.
// ----------------------------------------------------------------------------
package fadd_pkg;
   localparam int EXP_W   = 8;
   localparam int FRAC_W  = 23;
   localparam int WORD_W  = 1 + EXP_W + FRAC_W;
   localparam int MAG_W   = EXP_W + FRAC_W;
   localparam int EXTRA   = 3;
   localparam int MANT_W  = FRAC_W + 1 + EXTRA;       // 27
   localparam int SUM_W   = MANT_W + 1;               // 28
   localparam int SHAMT_W = $clog2(SUM_W + 1);
   localparam int FAR_D   = FRAC_W + EXTRA + 2;
   localparam logic [EXP_W-1:0] EXP_ALL = '1;
   localparam logic [WORD_W-1:0] QNAN =
      {1'b0, EXP_ALL, 1'b1, {(FRAC_W-1){1'b0}}};

   // aligned operands, after the first stage
   typedef struct packed {
      logic              special;
      logic [WORD_W-1:0] special_word;
      logic              sign_a;
      logic              sign_l;
      logic              subtract;
      logic [EXP_W-1:0]  exp_l;
      logic [MANT_W-1:0] mant_l;
      logic [MANT_W-1:0] mant_s;
   } align_type;

   // raw sum, after the second stage
   typedef struct packed {
      logic              special;
      logic [WORD_W-1:0] special_word;
      logic              sign_a;
      logic              sign_l;
      logic [EXP_W-1:0]  exp_l;
      logic [SUM_W-1:0]  sum;
   } sum_type;
endpackage

>>> hdl/binary32_float_adder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary32_float_adder_unit
// Three-stage binary32 adder, round toward zero, overflow to infinity.
// ----------------------------------------------------------------------------
// channel | ports                                     | direction
// req     | req_valid req_stall req_operand_a/_b      | in
// rsp     | rsp_valid rsp_stall rsp_sum_bits/overflowed | out
// One transaction per cycle while rsp is not stalled; stages align, add, normalize.
// Synchronous active-high reset clears the stage valid bits only.
// A stall at rsp holds every stage that is full up to the first gap.
module binary32_float_adder_unit import fadd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [WORD_W-1:0] req_operand_a,
   input  logic [WORD_W-1:0] req_operand_b,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_sum_bits,
   output logic              rsp_overflowed
);
`include "binary32_float_adder_unit_macros.svh"
   align_type         align_in, align_ff;
   sum_type           sum_in, sum_ff;
   logic [WORD_W-1:0] word_in, word_ff;
   logic              ovf_in, ovf_ff;
   logic              v1_ff, v2_ff, v3_ff;
   logic              adv1, adv2, adv3;

   assign adv3 = !v3_ff || !rsp_stall;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_stall = !adv1;

   fadd_align u_align (.a(req_operand_a), .b(req_operand_b), .result(align_in));

   always_comb begin
      sum_in.special      = align_ff.special;
      sum_in.special_word = align_ff.special_word;
      sum_in.sign_a       = align_ff.sign_a;
      sum_in.sign_l       = align_ff.sign_l;
      sum_in.exp_l        = align_ff.exp_l;
      sum_in.sum = align_ff.subtract ?
         {1'b0, align_ff.mant_l} - {1'b0, align_ff.mant_s} :
         {1'b0, align_ff.mant_l} + {1'b0, align_ff.mant_s};
   end

   fadd_normalize u_norm (.op(sum_ff), .word(word_in), .ovf(ovf_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
      if (adv1) align_ff <= align_in;
      if (adv2) sum_ff <= sum_in;
      if (adv3) begin
         word_ff <= word_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_valid      = v3_ff;
   assign rsp_sum_bits   = word_ff;
   assign rsp_overflowed = ovf_ff;

   `FA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_sum_bits), "held result changed")
   `FA_ASSERT_IMP(a_ovf_inf, clock, reset, rsp_valid && rsp_overflowed,
      rsp_sum_bits[MAG_W-1:0] == {EXP_ALL, {FRAC_W{1'b0}}}, "overflow not infinity")
   `FA_ASSERT_NEXT(a_flow, clock, reset, v2_ff && adv3, v3_ff, "stage two item lost")
endmodule

>>> hdl/fadd_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fadd_align
// Unpack, classify and order operands; align the smaller one with sticky.
// ----------------------------------------------------------------------------
module fadd_align import fadd_pkg::*; (
   input  logic [WORD_W-1:0] a,
   input  logic [WORD_W-1:0] b,
   output align_type         result
);
   logic              sa, sb, nan_a, nan_b, inf_a, inf_b, a_big;
   logic [EXP_W-1:0]  ea, eb, el, es, xl, xs, d;
   logic [FRAC_W-1:0] fa, fb;
   logic [MANT_W-1:0] ml, ms, shifted, lost_mask;

   always_comb begin
      sa = a[WORD_W-1];
      sb = b[WORD_W-1];
      ea = a[MAG_W-1:FRAC_W];
      eb = b[MAG_W-1:FRAC_W];
      fa = a[FRAC_W-1:0];
      fb = b[FRAC_W-1:0];
      nan_a = (ea == EXP_ALL) && (fa != '0);
      nan_b = (eb == EXP_ALL) && (fb != '0);
      inf_a = (ea == EXP_ALL) && (fa == '0);
      inf_b = (eb == EXP_ALL) && (fb == '0);
      a_big = a[MAG_W-1:0] >= b[MAG_W-1:0];
      el = a_big ? ea : eb;
      es = a_big ? eb : ea;
      ml = {(el != '0), (a_big ? fa : fb), {EXTRA{1'b0}}};
      ms = {(es != '0), (a_big ? fb : fa), {EXTRA{1'b0}}};
      xl = (el != '0) ? el : EXP_W'(1);
      xs = (es != '0) ? es : EXP_W'(1);
      d  = xl - xs;
      if (d >= EXP_W'(FAR_D)) begin
         shifted = MANT_W'(ms != '0);
      end else begin
         lost_mask = ~({MANT_W{1'b1}} << d);
         shifted = (ms >> d) | MANT_W'((ms & lost_mask) != '0);
      end
      if (d == '0) begin
         shifted = ms;
      end
      lost_mask = ~({MANT_W{1'b1}} << d);
      result.special = nan_a || nan_b || inf_a || inf_b;
      if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
         result.special_word = QNAN;
      end else if (inf_a) begin
         result.special_word = {sa, EXP_ALL, {FRAC_W{1'b0}}};
      end else begin
         result.special_word = {sb, EXP_ALL, {FRAC_W{1'b0}}};
      end
      result.sign_a   = sa;
      result.sign_l   = a_big ? sa : sb;
      result.subtract = sa != sb;
      result.exp_l    = xl;
      result.mant_l   = ml;
      result.mant_s   = shifted;
   end
endmodule

>>> hdl/fadd_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fadd_normalize
// Normalize the raw sum, handle subnormal, overflow and zero, pass specials, pack result.
// ----------------------------------------------------------------------------
module fadd_normalize import fadd_pkg::*; (
   input  sum_type           op,
   output logic [WORD_W-1:0] word,
   output logic              ovf
);
   localparam logic [SUM_W-1:0] TOP = SUM_W'(1) << (MANT_W - 1);
   logic [SUM_W-1:0]   s;
   logic [EXP_W:0]     x;
   logic [SHAMT_W-1:0] lz, sh;

   always_comb begin
      s  = op.sum;
      x  = {1'b0, op.exp_l};
      ovf = 1'b0;
      sh = '0;
      lz = '0;
      for (int i = 0; i < SUM_W - 1; i++) begin
         if (op.sum[i]) begin
            lz = SHAMT_W'(SUM_W - 2 - i);
         end
      end
      if (op.special) begin
         word = op.special_word;
      end else if (op.sum == '0) begin
         word = {op.sign_a, {MAG_W{1'b0}}};
      end else begin
         if (s[SUM_W-1]) begin
            s = s >> 1;
            x = x + 1'b1;
            sh = '0;
         end else if ((EXP_W+1)'(lz) < x) begin
            sh = lz;
         end else begin
            sh = SHAMT_W'(x - 1'b1);
         end
         s = s << sh;
         x = x - (EXP_W+1)'(sh);
         if (s >= TOP && x >= {1'b0, EXP_ALL}) begin
            word = {op.sign_l, EXP_ALL, {FRAC_W{1'b0}}};
            ovf = 1'b1;
         end else begin
            word = {op.sign_l, (s >= TOP) ? x[EXP_W-1:0] : {EXP_W{1'b0}},
                    s[MANT_W-2:EXTRA]};
         end
      end
   end
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operand pairs into the binary32 adder and compares each sum and
// overflow flag against a table value or a bit-accurate round-toward-zero adder model.
// ----------------------------------------------------------------------------
module testbench import fadd_pkg::*; ();
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        known;
      logic [31:0] sum;
      logic        ovf;
   } vector_type;

   typedef struct packed {
      logic [31:0] sum;
      logic        ovf;
   } sum_flag_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_operand_a;
   logic [31:0] req_operand_b;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_sum_bits;
   logic        rsp_overflowed;

   sum_flag_type pending_sums[$];
   int          mismatches = 0;
   int          checked = 0;
   int          sent = 0;
   bit          calm = 0;

   binary32_float_adder_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sum_bits(rsp_sum_bits), .rsp_overflowed(rsp_overflowed)
   );

   function automatic sum_flag_type add_rtz(logic [31:0] a, logic [31:0] b);
      logic        sa, sb, sl, big;
      logic [7:0]  ea, eb, el, es;
      logic [22:0] fa, fb;
      logic [31:0] ml, ms, s, top, lost;
      int          xl, xs, d, x;
      sum_flag_type r;
      sa = a[31]; sb = b[31];
      ea = a[30:23]; eb = b[30:23];
      fa = a[22:0]; fb = b[22:0];
      r.ovf = 1'b0;
      if ((ea == EXP_ALL && fa != 0) || (eb == EXP_ALL && fb != 0) ||
          (ea == EXP_ALL && eb == EXP_ALL && sa != sb)) begin
         r.sum = QNAN;
      end else if (ea == EXP_ALL) begin
         r.sum = {sa, EXP_ALL, 23'd0};
      end else if (eb == EXP_ALL) begin
         r.sum = {sb, EXP_ALL, 23'd0};
      end else begin
         big = a[30:0] >= b[30:0];
         sl = big ? sa : sb;
         el = big ? ea : eb;
         es = big ? eb : ea;
         ml = {5'd0, el != 0, big ? fa : fb, 3'd0};
         ms = {5'd0, es != 0, big ? fb : fa, 3'd0};
         xl = (el != 0) ? el : 1;
         xs = (es != 0) ? es : 1;
         d = xl - xs;
         x = xl;
         top = 32'd1 << 26;
         if (d >= 28) begin
            ms = (ms != 0);
         end else if (d != 0) begin
            lost = ms & ((32'd1 << d) - 1);
            ms = (ms >> d) | (lost != 0);
         end
         s = (sa == sb) ? ml + ms : ml - ms;
         if (s == 0) begin
            r.sum = {sa, 31'd0};
         end else begin
            if (s >= (top << 1)) begin
               s = s >> 1;
               x++;
            end
            while (s < top && x > 1) begin
               s = s << 1;
               x--;
            end
            if (s >= top && x >= 255) begin
               r.sum = {sl, EXP_ALL, 23'd0};
               r.ovf = 1'b1;
            end else begin
               r.sum = {sl, (s >= top) ? 8'(x) : 8'd0, s[25:3]};
            end
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 7))
         0: v[30:23] = 8'd0;
         1: v[30:23] = EXP_ALL;
         2: v[30:23] = 8'(254 - $urandom_range(0, 2));
         3: v[30:23] = 8'(120 + $urandom_range(0, 15));
         default: ;
      endcase
      if ($urandom_range(0, 9) == 0) v[22:0] = 23'd0;
      return v;
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      sum_flag_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked++;
         if (pending_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %h", rsp_sum_bits);
         end else begin
            want = pending_sums.pop_front();
            if (rsp_sum_bits !== want.sum || rsp_overflowed !== want.ovf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%b, got %h/%b",
                           want.sum, want.ovf, rsp_sum_bits, rsp_overflowed);
            end
         end
      end
   end

   initial begin
      int stall_left;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_stall <= 1'b0;
         end else if (rsp_stall) begin
            if (--stall_left <= 0) rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 3);
            rsp_stall <= 1'b1;
         end
      end
   end

   task automatic send_pair(logic [31:0] a, logic [31:0] b, sum_flag_type want);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_sums.push_back(want);
      sent++;
      @(negedge clock);
   endtask

   vector_type vectors[] = '{
      '{32'h3F800000, 32'h3F800000, 1, 32'h40000000, 0},
      '{32'h7F7FFFFF, 32'h7F7FFFFF, 1, 32'h7F800000, 1},
      '{32'hFF7FFFFF, 32'hFF7FFFFF, 1, 32'hFF800000, 1},
      '{32'h00000000, 32'h80000000, 1, 32'h00000000, 0},
      '{32'h80000000, 32'h00000000, 1, 32'h80000000, 0},
      '{32'h80000000, 32'h80000000, 1, 32'h80000000, 0},
      '{32'h7FC00001, 32'h3F800000, 1, 32'h7FC00000, 0},
      '{32'h3F800000, 32'hFFFFFFFF, 1, 32'h7FC00000, 0},
      '{32'h7F800000, 32'hFF800000, 1, 32'h7FC00000, 0},
      '{32'h7F800000, 32'h3F800000, 1, 32'h7F800000, 0},
      '{32'h3F800000, 32'hFF800000, 1, 32'hFF800000, 0},
      '{32'h7F800000, 32'h7F800000, 1, 32'h7F800000, 0},
      '{32'hBF800000, 32'h3F800000, 1, 32'h80000000, 0},
      '{32'h3F800000, 32'hBF800000, 1, 32'h00000000, 0},
      '{32'h00000001, 32'h00000001, 0, 0, 0},
      '{32'h007FFFFF, 32'h00000001, 0, 0, 0},
      '{32'h00800000, 32'h80000001, 0, 0, 0},
      '{32'h3F800000, 32'h33800001, 0, 0, 0},
      '{32'h3F800000, 32'hB3800001, 0, 0, 0},
      '{32'h7F7FFFFF, 32'h00000001, 0, 0, 0},
      '{32'hFFFFFFFF, 32'h00000000, 0, 0, 0},
      '{32'h3FFFFFFF, 32'hBFFFFFFE, 0, 0, 0}
   };

   initial begin
      vector_type v;
      logic [31:0] a, b;
      int wait_cycles;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operand_a = '0;
      req_operand_b = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (vectors[i]) begin
         v = vectors[i];
         if (v.known && add_rtz(v.a, v.b) != {v.sum, v.ovf})
            $display("table row %0d disagrees with model", i);
         if (v.known) send_pair(v.a, v.b, sum_flag_type'({v.sum, v.ovf}));
         else send_pair(v.a, v.b, add_rtz(v.a, v.b));
      end
      for (int n = 0; n < 1950; n++) begin
         if (n == 1000) begin
            req_valid <= 1'b0;
            while (pending_sums.size() != 0) @(negedge clock);
         end
         if (n == 1700) calm = 1;
         a = random_operand();
         case ($urandom_range(0, 3))
            0: b = {~a[31], a[30:23], 23'($urandom_range(0, 3)) ^ a[22:0]};
            1: b = {$urandom_range(0, 1) == 1, 8'(a[30:23] - $urandom_range(0, 30)),
                    23'($urandom)};
            default: b = random_operand();
         endcase
         if ($urandom_range(0, 1) == 1) send_pair(a, b, add_rtz(a, b));
         else send_pair(b, a, add_rtz(b, a));
      end
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_sums.size() != 0 && wait_cycles < 1000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (8) @(negedge clock);
      $display("sent %0d operand pairs, checked %0d sums", sent, checked);
      $display("covered zeros, subnormals, cancellation, NaN, infinity and overflow");
      if (mismatches == 0 && pending_sums.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
